/* rtl/core/odw_pkg.sv */
// odw_pkg: shared constants and types for the oscillator octave / dac word core
// no dependencies; imported by odw_div, oscillator_octave_dac_word_core and tb_top
`timescale 1ns / 1ps

package odw_pkg;

    localparam int HZ_W     = 27;          // target frequency width
    localparam int OCT_W    = 4;
    localparam int DAC_W    = 10;
    localparam int ADDR_W   = 7;
    localparam int QUO_BITS = 11;          // quotient never exceeds 1024 for in-range frequencies
    localparam int DEN_W    = HZ_W + 1;    // divisor is 2*f
    localparam int REM_W    = 40;          // holds 4097*f - 2078*2^(11+oct)

    localparam logic [HZ_W-1:0]   FREQ_MIN   = 27'd1039;
    localparam logic [HZ_W-1:0]   FREQ_MAX   = 27'd68000000;
    localparam logic [REM_W-1:0]  DAC_REF    = 40'd2078;
    localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd23;
    localparam logic [1:0]        WORD_TAG   = 2'b10;
    localparam int                OCT_MAX    = 15;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic [OCT_W-1:0] oct;
        logic             oor;
    } t_side;

endpackage

/* rtl/core/odw_div.sv */
// odw_div: pipelined restoring divider, one quotient bit per register stage
// depends on odw_pkg (widths, t_side)
`timescale 1ns / 1ps

module odw_div
    import odw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [REM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [QUO_BITS-1:0] o_quo,
    output t_side            o_side
);

    logic                r_vld  [QUO_BITS];
    logic [REM_W-1:0]    r_rem  [QUO_BITS];
    logic [DEN_W-1:0]    r_den  [QUO_BITS];
    logic [QUO_BITS-1:0] r_quo  [QUO_BITS];
    t_side               r_side [QUO_BITS];
    logic [QUO_BITS:0]   move;

    assign move[QUO_BITS] = !i_stall;

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
        localparam int K = QUO_BITS - 1 - j;

        logic                vin;
        logic [REM_W-1:0]    rin;
        logic [DEN_W-1:0]    din;
        logic [QUO_BITS-1:0] qin;
        t_side               sin;
        logic [REM_W-1:0]    dsh;
        logic                ge;

        if (j == 0) begin : g_first
            assign vin = i_valid;
            assign rin = i_num;
            assign din = i_den;
            assign qin = '0;
            assign sin = i_side;
        end else begin : g_next
            assign vin = r_vld[j-1];
            assign rin = r_rem[j-1];
            assign din = r_den[j-1];
            assign qin = r_quo[j-1];
            assign sin = r_side[j-1];
        end

        assign dsh = {{(REM_W-DEN_W){1'b0}}, din} << K;
        assign ge  = (rin >= dsh);

        // a stage loads when empty or when its content moves on
        assign move[j] = !r_vld[j] || move[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (move[j]) begin
                r_vld[j] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (move[j]) begin
                r_rem[j]  <= ge ? (rin - dsh) : rin;
                r_den[j]  <= din;
                r_quo[j]  <= qin | (QUO_BITS'(ge) << K);
                r_side[j] <= sin;
            end
        end
    end

    assign o_stall = !move[0];
    assign o_valid = r_vld[QUO_BITS-1];
    assign o_quo   = r_quo[QUO_BITS-1];
    assign o_side  = r_side[QUO_BITS-1];

endmodule

/* rtl/core/oscillator_octave_dac_word_core.sv */
// oscillator_octave_dac_word_core: frequency to octave, dac code and setting word
// depends on odw_pkg and odw_div
`timescale 1ns / 1ps

// channel  | valid    | stall    | payload
// ---------+----------+----------+-----------------------------------------------
// input    | i_valid  | o_stall  | i_target_hz
// output   | o_valid  | i_stall  | o_octave o_dac_code o_word_high o_word_low
//          |          |          | o_bus_address_byte o_out_of_range
// config   | i_cfg_we | -        | i_cfg_wdata
//
// one transfer per cycle sustained while i_stall is low; registers in order:
// range/octave stage, numerator stage, 11 divider stages, output register
// the 11-stage restoring divider sets the depth, one quotient bit per stage
// each stage loads when empty or when its content moves on, so bubbles close up
// and the input keeps taking transfers while a result waits at the output, till all fill
// synchronous active-low reset clears valid bits and loads ADDR_RESET into the address register

module oscillator_octave_dac_word_core
    import odw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [HZ_W-1:0]   i_target_hz,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OCT_W-1:0]  o_octave,
    output logic [DAC_W-1:0]  o_dac_code,
    output logic [7:0]        o_word_high,
    output logic [7:0]        o_word_low,
    output logic [7:0]        o_bus_address_byte,
    output logic              o_out_of_range
);

    // device address register
    logic [ADDR_W-1:0] r_dev_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    // write direction bit is zero; the user must change the address only while idle, the block does not enforce it
    assign o_bus_address_byte = {r_dev_addr, 1'b0};

    // handshake chain, back to front
    logic out_move, div_stall, s2_move, s1_move;
    logic div_valid;

    // stage 1: range check and octave by threshold compares
    logic            r_s1_vld;
    logic [HZ_W-1:0] r_s1_f;
    logic            r_s1_oor;
    logic [OCT_W-1:0] r_s1_oct;
    logic [OCT_W-1:0] n_s1_oct;
    logic            n_s1_oor;

    // octave is the largest n with 1039 * 2^n <= f
    always_comb begin
        n_s1_oct = '0;
        for (int n = 1; n <= OCT_MAX; n++) begin
            if (i_target_hz >= (FREQ_MIN << n)) begin
                n_s1_oct = OCT_W'(n);
            end
        end
    end

    assign n_s1_oor = (i_target_hz < FREQ_MIN) || (i_target_hz > FREQ_MAX);

    assign s1_move = !r_s1_vld || s2_move;
    assign o_stall = !s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_move) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s1_f   <= i_target_hz;
            r_s1_oor <= n_s1_oor;
            r_s1_oct <= n_s1_oct;
        end
    end

    // stage 2: dividend 2t + f = 4097 f - 2078 * 2^(11+oct), divisor 2f
    logic             r_s2_vld;
    logic [REM_W-1:0] r_s2_num;
    logic [DEN_W-1:0] r_s2_den;
    t_side            r_s2_side;
    logic [REM_W-1:0] n_s2_num;
    logic [REM_W-1:0] f_ext;

    assign f_ext    = {{(REM_W-HZ_W){1'b0}}, r_s1_f};
    assign n_s2_num = (f_ext << 12) + f_ext - (DAC_REF << (r_s1_oct + 5'd11));

    assign s2_move = !r_s2_vld || !div_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_move) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_s2_num      <= n_s2_num;
            r_s2_den      <= {r_s1_f, 1'b0};
            r_s2_side.oct <= r_s1_oct;
            r_s2_side.oor <= r_s1_oor;
        end
    end

    // divider: rounded quotient (2t + f) / (2f)
    logic [QUO_BITS-1:0] div_quo;
    t_side               div_side;

    odw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .o_stall (div_stall),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_side  (r_s2_side),
        .o_valid (div_valid),
        .i_stall (!out_move),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // output register: saturate, build the setting word, zero when out of range
    logic             r_out_vld;
    logic [OCT_W-1:0] r_oct;
    logic [DAC_W-1:0] r_dac;
    logic             r_oor;
    logic [DAC_W-1:0] n_dac;
    logic [OCT_W-1:0] n_oct;

    // quotient of 1024 clamps to the top code
    assign n_dac = div_side.oor ? '0 :
                   (div_quo[QUO_BITS-1] ? {DAC_W{1'b1}} : div_quo[DAC_W-1:0]);
    assign n_oct = div_side.oor ? '0 : div_side.oct;

    assign out_move = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_move) begin
            r_out_vld <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move) begin
            r_oct <= n_oct;
            r_dac <= n_dac;
            r_oor <= div_side.oor;
        end
    end

    logic [15:0] word;

    assign word = r_oor ? 16'd0 : {r_oct, r_dac, WORD_TAG};

    assign o_valid        = r_out_vld;
    assign o_octave       = r_oct;
    assign o_dac_code     = r_dac;
    assign o_word_high    = word[15:8];
    assign o_word_low     = word[7:0];
    assign o_out_of_range = r_oor;

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for the oscillator octave / dac word core
// drives random and corner frequencies through the valid/stall channels and
// checks every result against an in-bench predictor; needs odw_pkg and the core
`timescale 1ns / 1ps

module tb_top;
    import odw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int LONG_HOLD   = 400;     // receiver hold-off used for back-pressure
    localparam int TAIL_CYCLES = 20;      // pipeline depth is 14, plus margin

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } t_idle_style;

    // one expected setting, tagged with the frequency that caused it
    typedef struct packed {
        logic [HZ_W-1:0]  hz;
        logic [OCT_W-1:0] octave;
        logic [DAC_W-1:0] dac_code;
        logic [7:0]       word_high;
        logic [7:0]       word_low;
        logic [7:0]       bus_address_byte;
        logic             out_of_range;
    } t_dac_setting;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [HZ_W-1:0]   i_target_hz = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [OCT_W-1:0]  o_octave;
    logic [DAC_W-1:0]  o_dac_code;
    logic [7:0]        o_word_high;
    logic [7:0]        o_word_low;
    logic [7:0]        o_bus_address_byte;
    logic              o_out_of_range;

    logic [HZ_W-1:0]   hz_pending[$];     // frequencies waiting for the driver
    t_dac_setting      setting_due[$];    // predicted settings, oldest first
    logic [ADDR_W-1:0] address_shadow = ADDR_RESET;

    t_idle_style       send_style = IDLE_NONE;
    t_idle_style       recv_style = IDLE_NONE;
    int                hold_req_cnt = 0;  // bumped by the sequencer to ask for a hold-off
    int                hold_ack_cnt = 0;

    // handshake flags sampled at the rising edge, read by the drivers at the falling edge
    logic              in_fire = 1'b0;
    logic              out_fire = 1'b0;
    int                mismatches = 0;
    int                cycle_count = 0;

    oscillator_octave_dac_word_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_target_hz        (i_target_hz),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_octave           (o_octave),
        .o_dac_code         (o_dac_code),
        .o_word_high        (o_word_high),
        .o_word_low         (o_word_low),
        .o_bus_address_byte (o_bus_address_byte),
        .o_out_of_range     (o_out_of_range)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor: exact octave by leading-one search, dac by integer rounding
    function automatic t_dac_setting calc_setting(logic [HZ_W-1:0] hz,
                                                  logic [ADDR_W-1:0] addr);
        t_dac_setting s;
        logic [63:0]  f;
        logic [63:0]  q;
        logic [63:0]  num;
        logic [63:0]  t;
        logic [63:0]  dac;
        int           oct;
        logic [15:0]  word;
        s = '0;
        s.hz = hz;
        f = 64'(hz);
        oct = 0;
        if (hz < FREQ_MIN || hz > FREQ_MAX) begin
            s.out_of_range = 1'b1;
        end else begin
            q = f / 64'd1039;
            while (q > 64'd1) begin
                q = q >> 1;
                oct++;
            end
            num = 64'd2078 << (10 + oct);
            t = 64'd2048 * f;
            t = (t >= num) ? (t - num) : 64'd0;
            dac = (64'd2 * t + f) / (64'd2 * f);
            // just below an octave boundary the rounded code can hit 1024
            if (dac > 64'd1023)
                dac = 64'd1023;
            word = {4'(oct), dac[9:0], WORD_TAG};
            s.octave    = 4'(oct);
            s.dac_code  = dac[9:0];
            s.word_high = word[15:8];
            s.word_low  = word[7:0];
        end
        s.bus_address_byte = {addr, 1'b0};
        return s;
    endfunction

    // per-transfer wait drawn from 0..15, or mostly zero, or always zero
    function automatic int draw_wait(t_idle_style style);
        case (style)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            default:    return $urandom_range(0, 15);
        endcase
    endfunction

    // random frequency: mostly spread over all octaves, some near edges, some raw noise
    function automatic logic [HZ_W-1:0] pick_hz();
        int          kind;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] f;
        kind = $urandom_range(0, 9);
        k = $urandom_range(0, OCT_MAX);
        lo = 32'd1039 << k;
        hi = (32'd1039 << (k + 1)) - 32'd1;
        if (hi > 32'd68000000)
            hi = 32'd68000000;
        if (kind == 0) begin
            f = $urandom() & 32'h07ff_ffff;
        end else if (kind == 1) begin
            // around an octave boundary, the saturation zone or the top limit
            case ($urandom_range(0, 2))
                0:       f = lo + $urandom_range(0, 6) - 3;
                1:       f = hi + $urandom_range(0, 6) - 3;
                default: f = 32'd68000000 + $urandom_range(0, 6) - 3;
            endcase
        end else begin
            f = $urandom_range(hi, lo);
        end
        return f[HZ_W-1:0];
    endfunction

    // rising edge: record transfers, predict on input, check on output
    always @(posedge i_clk) begin
        t_dac_setting exp_s;
        if (!i_rst_n) begin
            in_fire = 1'b0;
            out_fire = 1'b0;
        end else begin
            cycle_count++;
            in_fire = i_valid && !o_stall;
            out_fire = o_valid && !i_stall;
            if (in_fire)
                setting_due.push_back(calc_setting(i_target_hz, address_shadow));
            if (out_fire) begin
                if (setting_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("extra result oct=%0d dac=%0d hi=%02h lo=%02h adr=%02h oor=%0b",
                                 o_octave, o_dac_code, o_word_high, o_word_low,
                                 o_bus_address_byte, o_out_of_range);
                    mismatches++;
                end else begin
                    exp_s = setting_due.pop_front();
                    if (o_octave !== exp_s.octave || o_dac_code !== exp_s.dac_code ||
                        o_word_high !== exp_s.word_high || o_word_low !== exp_s.word_low ||
                        o_bus_address_byte !== exp_s.bus_address_byte ||
                        o_out_of_range !== exp_s.out_of_range) begin
                        if (mismatches < 10) begin
                            $display("mismatch hz=%0d", exp_s.hz);
                            $display("  exp oct=%0d dac=%0d hi=%02h lo=%02h adr=%02h oor=%0b",
                                     exp_s.octave, exp_s.dac_code, exp_s.word_high,
                                     exp_s.word_low, exp_s.bus_address_byte,
                                     exp_s.out_of_range);
                            $display("  got oct=%0d dac=%0d hi=%02h lo=%02h adr=%02h oor=%0b",
                                     o_octave, o_dac_code, o_word_high, o_word_low,
                                     o_bus_address_byte, o_out_of_range);
                        end
                        mismatches++;
                    end
                end
            end
            // register write lands at this edge; only done while the core is idle
            if (i_cfg_we)
                address_shadow = i_cfg_wdata;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // sender: falling edge, one payload per transfer, held while stalled
    always @(negedge i_clk) begin
        logic next_valid;
        int   gap_left;
        if (!i_rst_n) begin
            gap_left = 0;
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            if (i_valid && in_fire)
                next_valid = 1'b0;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (hz_pending.size() != 0) begin
                    i_target_hz <= hz_pending.pop_front();
                    next_valid = 1'b1;
                    gap_left = draw_wait(send_style);
                end
            end
            i_valid <= next_valid;
        end
    end

    // receiver: falling edge, random stall after each result plus the long hold-off
    always @(negedge i_clk) begin
        int stall_left;
        int hold_left;
        if (!i_rst_n) begin
            stall_left = 0;
            hold_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (hold_ack_cnt != hold_req_cnt) begin
                hold_ack_cnt = hold_req_cnt;
                hold_left = LONG_HOLD;
            end
            if (out_fire)
                stall_left = draw_wait(recv_style);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // wait until every queued frequency went in and every setting came out
    task automatic drain_to_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (hz_pending.size() != 0 || i_valid || setting_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_address(logic [ADDR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int count);
        repeat (count) hz_pending.push_back(pick_hz());
    endtask

    task automatic pick_styles();
        send_style = t_idle_style'($urandom_range(0, 2));
        recv_style = t_idle_style'($urandom_range(0, 2));
    endtask

    // sequencer
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: range limits, octave edges, saturation just below a boundary
        send_style = IDLE_NONE;
        recv_style = IDLE_NONE;
        hz_pending.push_back(27'd0);
        hz_pending.push_back(27'd1);
        hz_pending.push_back(27'd1038);
        hz_pending.push_back(27'd1039);
        hz_pending.push_back(27'd1040);
        hz_pending.push_back(27'd1500);
        hz_pending.push_back(27'd2077);
        hz_pending.push_back(27'd2078);
        hz_pending.push_back(27'd4155);
        hz_pending.push_back(27'd4156);
        hz_pending.push_back(27'd1063935);
        hz_pending.push_back(27'd1063936);
        hz_pending.push_back(27'd1000000);
        hz_pending.push_back(27'd12345678);
        hz_pending.push_back(27'd34045951);
        hz_pending.push_back(27'd34045952);
        hz_pending.push_back(27'd67108864);
        hz_pending.push_back(27'd67999999);
        hz_pending.push_back(27'd68000000);
        hz_pending.push_back(27'd68000001);
        hz_pending.push_back(27'h3ff_ffff);
        hz_pending.push_back(27'h7ff_ffff);
        drain_to_idle();

        // reset address, random idling on both sides
        pick_styles();
        queue_random(130);
        drain_to_idle();

        // lowest address
        write_address(7'd0);
        pick_styles();
        queue_random(150);
        drain_to_idle();

        // highest address; receiver holds off while the sender keeps offering
        write_address(7'd127);
        send_style = IDLE_NONE;
        recv_style = IDLE_LIGHT;
        queue_random(150);
        hold_req_cnt++;
        drain_to_idle();

        // random address, sender pauses mid-phase until all results are back
        write_address(7'($urandom_range(1, 126)));
        pick_styles();
        queue_random(80);
        drain_to_idle();
        pick_styles();
        queue_random(80);
        drain_to_idle();

        if (mismatches == 0 && setting_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
